@@ src/gf3_pkg.sv @@
// shared types, constants and register codes of the 3x3 gaussian filter
package gf3_pkg;

  localparam int MAX_WIDTH        = 1024;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int MIN_WIDTH        = 3;

  localparam int PIX_W       = 8;
  localparam int OUT_W       = 16;
  localparam int WEIGHT_W    = 16;
  localparam int ROW_WIDTH_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CMP_W       = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
  localparam int SUM4_W      = PIX_W + 2;
  localparam int PROD_W      = SUM4_W + WEIGHT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int ROUND_SH    = WEIGHT_FRAC_BITS - 8;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int CRED_W      = QCNT_W + 1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(512);
  localparam logic [WEIGHT_W-1:0]    CORNER_RST    = WEIGHT_W'(4922);
  localparam logic [WEIGHT_W-1:0]    EDGE_RST      = WEIGHT_W'(8116);
  localparam logic [WEIGHT_W-1:0]    CENTER_RST    = WEIGHT_W'(13381);
  localparam logic [1:0]             ROWS_FULL     = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH = 2'd0,
    REG_CORNER    = 2'd1,
    REG_EDGE      = 2'd2,
    REG_CENTER    = 2'd3
  } gf3_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } gf3_op_e;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel;
  } gf3_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] filtered;
    logic             end_of_frame;
  } gf3_out_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] corner_weight;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [WEIGHT_W-1:0] center_weight;
  } gf3_weights_t;

  // decoded per-item control, issued at acceptance
  typedef struct packed {
    logic             fl;
    logic             rs0;
    logic             first;
    logic             last;
    logic             emit;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } gf3_issue_t;

  // one assembled column, top to bottom, with its control
  typedef struct packed {
    logic                  fl;
    logic                  first;
    logic                  last;
    logic                  emit;
    logic [2:0][PIX_W-1:0] pix;
  } gf3_column_t;

endpackage

@@ src/gf3_ctrl.sv @@
// configuration registers and raster scan control
module gf3_ctrl import gf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  gf3_in_t               in_data_i,
  output gf3_weights_t          weights_o,
  output logic                  iss_valid_o,
  output gf3_issue_t            iss_o
);

  logic [ROW_WIDTH_W-1:0] row_width_q;
  gf3_weights_t           weights_q;
  logic [COL_W-1:0]       col_cnt_q, col_cnt_d;
  logic [1:0]             rows_seen_q, rows_seen_d;
  logic                   flushing_q, flushing_d;

  logic [CMP_W-1:0] rw_ext, w_use, c_inc;
  logic             is_flush, flush_ok, ignore, fl, last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q             <= ROW_WIDTH_RST;
      weights_q.corner_weight <= CORNER_RST;
      weights_q.edge_weight   <= EDGE_RST;
      weights_q.center_weight <= CENTER_RST;
    end else if (cfg_we_i) begin
      unique case (gf3_reg_e'(cfg_idx_i))
        REG_ROW_WIDTH: row_width_q             <= cfg_data_i[ROW_WIDTH_W-1:0];
        REG_CORNER:    weights_q.corner_weight <= cfg_data_i[WEIGHT_W-1:0];
        REG_EDGE:      weights_q.edge_weight   <= cfg_data_i[WEIGHT_W-1:0];
        REG_CENTER:    weights_q.center_weight <= cfg_data_i[WEIGHT_W-1:0];
        default:       row_width_q             <= row_width_q;
      endcase
    end
  end

  always_comb begin
    rw_ext = CMP_W'(row_width_q);
    if (rw_ext < CMP_W'(MIN_WIDTH)) begin
      w_use = CMP_W'(MIN_WIDTH);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      w_use = CMP_W'(MAX_WIDTH);
    end else begin
      w_use = rw_ext;
    end
    c_inc    = CMP_W'(col_cnt_q) + CMP_W'(1);
    last     = (c_inc >= w_use);
    is_flush = (gf3_op_e'(in_data_i.opcode) == OP_FLUSH);
    // a flush may only start at a row boundary once a row has been seen
    flush_ok = (col_cnt_q == '0) && (rows_seen_q != 2'd0);
    ignore   = !flushing_q && is_flush && !flush_ok;
    fl       = flushing_q || is_flush;

    col_cnt_d   = col_cnt_q;
    rows_seen_d = rows_seen_q;
    flushing_d  = flushing_q;
    if (accept_i && !ignore) begin
      if (last) begin
        col_cnt_d  = '0;
        flushing_d = 1'b0;
        if (fl) begin
          rows_seen_d = 2'd0;
        end else if (rows_seen_q != ROWS_FULL) begin
          rows_seen_d = rows_seen_q + 2'd1;
        end
      end else begin
        col_cnt_d  = c_inc[COL_W-1:0];
        flushing_d = fl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      rows_seen_q <= 2'd0;
      flushing_q  <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      rows_seen_q <= rows_seen_d;
      flushing_q  <= flushing_d;
    end
  end

  assign iss_valid_o = accept_i && !ignore;
  assign iss_o.fl    = fl;
  assign iss_o.rs0   = (rows_seen_q == 2'd0);
  assign iss_o.first = (col_cnt_q == '0);
  assign iss_o.last  = last;
  assign iss_o.emit  = fl || (rows_seen_q != 2'd0);
  assign iss_o.col   = col_cnt_q;
  assign iss_o.pixel = in_data_i.pixel;
  assign weights_o   = weights_q;

endmodule

@@ src/gf3_rowbuf.sv @@
// row buffers with registered read and column assembly
module gf3_rowbuf import gf3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        iss_valid_i,
  input  gf3_issue_t  iss_i,
  output logic        col_valid_o,
  output gf3_column_t col_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  gf3_issue_t       iss_q;
  logic             valid_q;
  logic [PIX_W-1:0] c0, c1, c2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= iss_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid_i) begin
      up_rd_q  <= upper_mem[iss_i.col];
      mid_rd_q <= middle_mem[iss_i.col];
      iss_q    <= iss_i;
    end
  end

  always_comb begin
    if (iss_q.fl) begin
      // bottom row replicated below itself
      c0 = up_rd_q;
      c1 = mid_rd_q;
      c2 = mid_rd_q;
    end else begin
      // first image row also stands in for the rows above it
      c0 = iss_q.rs0 ? iss_q.pixel : up_rd_q;
      c1 = iss_q.rs0 ? iss_q.pixel : mid_rd_q;
      c2 = iss_q.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q && !iss_q.fl) begin
      upper_mem[iss_q.col]  <= c1;
      middle_mem[iss_q.col] <= iss_q.pixel;
    end
  end

  assign col_valid_o = valid_q;
  assign col_o.fl    = iss_q.fl;
  assign col_o.first = iss_q.first;
  assign col_o.last  = iss_q.last;
  assign col_o.emit  = iss_q.emit;
  assign col_o.pix   = {c2, c1, c0};

endmodule

@@ src/gf3_mac.sv @@
// column window, weighted products, rounding and saturation
module gf3_mac import gf3_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gf3_weights_t weights_i,
  input  logic         col_valid_i,
  input  gf3_column_t  col_i,
  output logic         prod_valid_o,
  output logic         res_a_valid_o,
  output gf3_out_t     res_a_o,
  output logic         res_b_valid_o,
  output gf3_out_t     res_b_o
);

  localparam logic [ACC_W-1:0] RND = ACC_W'((1 << ROUND_SH) >> 1);

  logic [2:0][PIX_W-1:0]  win_l_q, win_m_q;
  logic [2:0][PROD_W-1:0] prod_a_q, prod_b_q;
  logic                   a_valid_q, b_valid_q, eof_q;
  logic [2:0][PROD_W-1:0] prod_a, prod_b;
  logic                   a_hit, b_hit;

  function automatic logic [2:0][PROD_W-1:0] weigh(
    input logic [2:0][PIX_W-1:0] l,
    input logic [2:0][PIX_W-1:0] m,
    input logic [2:0][PIX_W-1:0] r,
    input gf3_weights_t          wt
  );
    logic [SUM4_W-1:0]      diag, orth;
    logic [2:0][PROD_W-1:0] p;
    diag = SUM4_W'(l[0]) + SUM4_W'(l[2]) + SUM4_W'(r[0]) + SUM4_W'(r[2]);
    orth = SUM4_W'(l[1]) + SUM4_W'(r[1]) + SUM4_W'(m[0]) + SUM4_W'(m[2]);
    p[0] = PROD_W'(diag) * PROD_W'(wt.corner_weight);
    p[1] = PROD_W'(orth) * PROD_W'(wt.edge_weight);
    p[2] = PROD_W'(m[1]) * PROD_W'(wt.center_weight);
    return p;
  endfunction

  function automatic gf3_out_t finish(input logic [2:0][PROD_W-1:0] p, input logic eof);
    logic [ACC_W-1:0] acc, sh;
    gf3_out_t         r;
    acc = ACC_W'(p[0]) + ACC_W'(p[1]) + ACC_W'(p[2]) + RND;
    sh  = acc >> ROUND_SH;
    r.filtered     = (sh[ACC_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : sh[OUT_W-1:0];
    r.end_of_frame = eof;
    return r;
  endfunction

  // first result: window plus new column; second, at row end: right edge replicated
  assign prod_a = weigh(win_l_q, win_m_q, col_i.pix, weights_i);
  assign prod_b = weigh(win_m_q, col_i.pix, col_i.pix, weights_i);
  assign a_hit  = col_valid_i && !col_i.first && col_i.emit;
  assign b_hit  = a_hit && col_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_l_q   <= '0;
      win_m_q   <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_hit;
      b_valid_q <= b_hit;
      if (col_valid_i) begin
        win_l_q <= col_i.first ? col_i.pix : win_m_q;
        win_m_q <= col_i.pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_hit) begin
      prod_a_q <= prod_a;
      prod_b_q <= prod_b;
      eof_q    <= col_i.fl;
    end
  end

  assign prod_valid_o  = a_valid_q;
  assign res_a_valid_o = a_valid_q;
  assign res_a_o       = finish(prod_a_q, 1'b0);
  assign res_b_valid_o = b_valid_q;
  assign res_b_o       = finish(prod_b_q, eof_q);

endmodule

@@ src/gf3_outq.sv @@
// result queue with two write ports and one read port
module gf3_outq import gf3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wa_i,
  input  gf3_out_t          da_i,
  input  logic              wb_i,
  input  gf3_out_t          db_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gf3_out_t          out_data_o,
  output logic [QCNT_W-1:0] count_o
);

  gf3_out_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q, wp_b;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  assign pop  = (cnt_q != '0) && !out_stall_i;
  assign wp_b = wa_i ? wp_q + QPTR_W'(1) : wp_q;

  always_ff @(posedge clk_i) begin
    if (wa_i) begin
      mem_q[wp_q] <= da_i;
    end
    if (wb_i) begin
      mem_q[wp_b] <= db_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QPTR_W'(wa_i) + QPTR_W'(wb_i);
      rp_q  <= rp_q + QPTR_W'(pop);
      cnt_q <= cnt_q + QCNT_W'(wa_i) + QCNT_W'(wb_i) - QCNT_W'(pop);
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign count_o     = cnt_q;

endmodule

@@ src/gaussian_3x3_filter_replicate_edges.sv @@
// top level of the 3x3 gaussian filter with edge replication
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | sink      | in_valid_i / in_stall_o    | in_data_i  (opcode, pixel)
//  out     | source    | out_valid_o / out_stall_i  | out_data_o (filtered, eof)
//  cfg     | sink      | cfg_we_i, cfg_idx_i        | cfg_data_i
//
//  one input transaction per cycle unless stalled; the single output port moves
//  one result per cycle unless stalled, so a stream of row-end pixels (two
//  results each) is bound by that port; results pass the row buffer and product
//  registers before the queue write, and out_valid_o rises once they are stored
//  reset clears the scan state and queue; row buffers need no clearing pass
//  in_stall_o rises only when the result queue lacks room for everything in flight
module gaussian_3x3_filter_replicate_edges import gf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gf3_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gf3_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              accept;
  gf3_weights_t      weights;
  logic              iss_valid;
  gf3_issue_t        iss;
  logic              col_valid;
  gf3_column_t       col;
  logic              prod_valid;
  logic              res_a_valid, res_b_valid;
  gf3_out_t          res_a, res_b;
  logic [QCNT_W-1:0] q_count;
  logic [CRED_W-1:0] committed;

  // every item in the pipe may still add two entries to the queue
  assign committed = CRED_W'(q_count) + CRED_W'({col_valid, 1'b0})
                   + CRED_W'({prod_valid, 1'b0});
  assign in_stall_o = (committed > CRED_W'(QUEUE_DEPTH - 2));
  assign accept     = in_valid_i && !in_stall_o;

  // scan position, rows seen, flush sequencing and config registers
  gf3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .weights_o   (weights),
    .iss_valid_o (iss_valid),
    .iss_o       (iss)
  );

  // row buffer read at acceptance, write back in the following cycle except during a flush
  gf3_rowbuf u_rowbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_valid_i (iss_valid),
    .iss_i       (iss),
    .col_valid_o (col_valid),
    .col_o       (col)
  );

  // window shift and products, then sum, round and saturate
  gf3_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .weights_i     (weights),
    .col_valid_i   (col_valid),
    .col_i         (col),
    .prod_valid_o  (prod_valid),
    .res_a_valid_o (res_a_valid),
    .res_a_o       (res_a),
    .res_b_valid_o (res_b_valid),
    .res_b_o       (res_b)
  );

  // output result queue: decouples the stall of the far side
  gf3_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wa_i        (res_a_valid),
    .da_i        (res_a),
    .wb_i        (res_b_valid),
    .db_i        (res_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (q_count)
  );

endmodule

@@ verif/gaussian_3x3_filter_replicate_edges_tb.sv @@
// self-checking testbench of the 3x3 gaussian filter: directed plan, then random frames
module gaussian_3x3_filter_replicate_edges_tb;
  import gf3_pkg::*;

  // random gap or stall drawn per transaction, from zero up to this many cycles
  localparam int MAX_GAP       = 13;
  // quiet cycles after the last expected result before a register write
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ITEMS  = 900;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PLAN_LEN      = 46;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_SETTLE
  } plan_kind_e;

  // one row of the directed plan; fixed marks a result value known by inspection
  typedef struct packed {
    plan_kind_e             kind;
    gf3_op_e                op;
    logic [PIX_W-1:0]       pix;
    logic                   fixed;
    logic [OUT_W-1:0]       fixed_px;
    gf3_reg_e               reg_sel;
    logic [CFG_DATA_W-1:0]  cfg_val;
  } plan_row_t;

  localparam plan_row_t SETTLE_ROW =
    '{STEP_SETTLE, OP_PIXEL, '0, 1'b0, '0, REG_ROW_WIDTH, '0};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  gf3_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  gf3_out_t              out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gaussian_3x3_filter_replicate_edges DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the configuration registers
  logic [ROW_WIDTH_W-1:0] width_reg;
  logic [WEIGHT_W-1:0]    corner_reg;
  logic [WEIGHT_W-1:0]    edge_reg;
  logic [WEIGHT_W-1:0]    center_reg;

  // shadow of the scan state: two row buffers, the column window and the row counters
  logic [PIX_W-1:0]          upper_buf [MAX_WIDTH];
  logic [PIX_W-1:0]          mid_buf   [MAX_WIDTH];
  logic [2:0][PIX_W-1:0]     win_left;
  logic [2:0][PIX_W-1:0]     win_mid;
  int                        col_idx;
  int                        rows_done;
  bit                        in_flush;

  // filtered pixels still owed by the block, oldest first
  gf3_out_t  expected_px [$];

  plan_row_t directed_plan [PLAN_LEN];
  int        mismatch_count;
  int        items_taken;
  int        cycle_count;
  bit        no_idle;

  // clock, period of two time units
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int clamp_width(input logic [ROW_WIDTH_W-1:0] raw);
    int w;
    w = int'(raw);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // weighted 3x3 sum, rounded half up to q8.8 and saturated
  function automatic logic [OUT_W-1:0] blur_px(input logic [2:0][PIX_W-1:0] lf,
                                               input logic [2:0][PIX_W-1:0] md,
                                               input logic [2:0][PIX_W-1:0] rt);
    longint unsigned diag;
    longint unsigned orth;
    longint unsigned acc;
    diag = lf[0] + lf[2] + rt[0] + rt[2];
    orth = lf[1] + rt[1] + md[0] + md[2];
    acc  = diag * corner_reg + orth * edge_reg + md[1] * center_reg;
    if (ROUND_SH > 0) acc = (acc + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return (acc > 64'd65535) ? {OUT_W{1'b1}} : acc[OUT_W-1:0];
  endfunction

  // advance the shadow state by one transaction and queue the pixels it releases
  task automatic predict_filter(input gf3_in_t it, output bit taken);
    int                    w;
    int                    c;
    bit                    last_col;
    bit                    emit;
    logic [2:0][PIX_W-1:0] cur;
    gf3_out_t              r;
    w     = clamp_width(width_reg);
    taken = 1'b1;
    // flush only starts at a row boundary after at least one row
    if (!in_flush && it.opcode == OP_FLUSH) begin
      if (col_idx != 0 || rows_done == 0) begin
        taken = 1'b0;
        return;
      end
      in_flush = 1'b1;
    end
    c        = (col_idx >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_idx;
    last_col = (c + 1 >= w);
    emit     = in_flush || rows_done > 0;
    if (in_flush) begin
      // bottom row replicated below itself, pixel field ignored
      cur[0] = upper_buf[c];
      cur[1] = mid_buf[c];
      cur[2] = mid_buf[c];
    end else begin
      // the first row stands in for the row above it
      cur[0] = (rows_done == 0) ? it.pixel : upper_buf[c];
      cur[1] = (rows_done == 0) ? it.pixel : mid_buf[c];
      cur[2] = it.pixel;
      upper_buf[c] = cur[1];
      mid_buf[c]   = it.pixel;
    end
    if (c == 0) begin
      // left edge replicated
      win_left = cur;
      win_mid  = cur;
    end else begin
      if (emit) begin
        r.filtered     = blur_px(win_left, win_mid, cur);
        r.end_of_frame = 1'b0;
        expected_px.push_back(r);
      end
      win_left = win_mid;
      win_mid  = cur;
      // right edge replicated, second pixel at the row end
      if (last_col && emit) begin
        r.filtered     = blur_px(win_left, win_mid, cur);
        r.end_of_frame = in_flush;
        expected_px.push_back(r);
      end
    end
    if (last_col) begin
      col_idx = 0;
      if (in_flush) begin
        in_flush  = 1'b0;
        rows_done = 0;
      end else if (rows_done < 2) begin
        rows_done++;
      end
    end else begin
      col_idx = c + 1;
    end
  endtask

  // drive one input transaction after a random gap, predict once accepted
  task automatic send_item(input gf3_op_e op, input logic [PIX_W-1:0] pix,
                           input bit fixed, input logic [OUT_W-1:0] fixed_px);
    int      gap;
    int      n0;
    bit      taken;
    gf3_in_t it;
    it.opcode = op;
    it.pixel  = pix;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    n0 = expected_px.size();
    predict_filter(it, taken);
    if (taken) items_taken++;
    // values known by inspection replace the predicted ones
    if (fixed) begin
      for (int k = n0; k < expected_px.size(); k++) expected_px[k].filtered = fixed_px;
    end
  endtask

  // sender holds off until every owed pixel is out and the pipeline is quiet
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input gf3_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      REG_ROW_WIDTH: width_reg  = val[ROW_WIDTH_W-1:0];
      REG_CORNER:    corner_reg = val;
      REG_EDGE:      edge_reg   = val;
      REG_CENTER:    center_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic plan_row_t item_row(input gf3_op_e op, input logic [PIX_W-1:0] pix,
                                         input bit fixed, input logic [OUT_W-1:0] val);
    return '{STEP_ITEM, op, pix, fixed, val, REG_ROW_WIDTH, '0};
  endfunction

  function automatic plan_row_t cfg_row(input gf3_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    return '{STEP_CFG, OP_PIXEL, '0, 1'b0, '0, idx, val};
  endfunction

  // mostly uniform, with the extremes favored
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // gaussian-like magnitudes in half the modes, full range and extremes otherwise
  function automatic logic [WEIGHT_W-1:0] pick_weight(input int mode, input int typical);
    case (mode)
      2:       return WEIGHT_W'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
      end
      default: return WEIGHT_W'($urandom_range(0, typical));
    endcase
  endfunction

  // one frame: configure while idle, rows of pixels with some noise, then the flush
  task automatic run_frame(input logic [CFG_DATA_W-1:0] width_val, input int n_rows);
    int eff_w;
    int mode;
    settle_block();
    write_reg(REG_ROW_WIDTH, width_val);
    mode = $urandom_range(0, 3);
    write_reg(REG_CORNER, pick_weight(mode, 8000));
    write_reg(REG_EDGE, pick_weight(mode, 12000));
    write_reg(REG_CENTER, pick_weight(mode, 20000));
    eff_w = clamp_width(width_val[ROW_WIDTH_W-1:0]);
    // flush before any row is dropped
    if ($urandom_range(0, 3) == 0) send_item(OP_FLUSH, rand_pixel(), 1'b0, '0);
    for (int r = 0; r < n_rows; r++) begin
      for (int c = 0; c < eff_w; c++) begin
        send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
        // flush in the middle of a row is dropped
        if (c < eff_w - 1 && $urandom_range(0, 15) == 0)
          send_item(OP_FLUSH, rand_pixel(), 1'b0, '0);
      end
    end
    // first step must be a flush, later pixel transactions act as flush steps
    for (int c = 0; c < eff_w; c++) begin
      send_item((c == 0 || $urandom_range(0, 2) != 0) ? OP_FLUSH : OP_PIXEL,
                rand_pixel(), 1'b0, '0);
    end
  endtask

  // check each accepted result against the oldest owed pixel
  task automatic check_result(input gf3_out_t got);
    gf3_out_t want;
    if (expected_px.size() == 0) begin
      $display("%0t: result with nothing owed: expected none, actual filtered %0d eof %0b",
               $time, got.filtered, got.end_of_frame);
      mismatch_count++;
    end else begin
      want = expected_px.pop_front();
      if (got.filtered !== want.filtered) begin
        $display("%0t: filtered mismatch: expected %0d, actual %0d",
                 $time, want.filtered, got.filtered);
        mismatch_count++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                 $time, want.end_of_frame, got.end_of_frame);
        mismatch_count++;
      end
    end
  endtask

  // receiving side: random stall before each result transaction
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_result(out_data_o);
    end
  end

  initial begin : stimulus
    int frame_idx;
    int w_raw;
    int pick;
    // shadow state at reset
    width_reg      = ROW_WIDTH_RST;
    corner_reg     = CORNER_RST;
    edge_reg       = EDGE_RST;
    center_reg     = CENTER_RST;
    win_left       = '0;
    win_mid        = '0;
    col_idx        = 0;
    rows_done      = 0;
    in_flush       = 1'b0;
    mismatch_count = 0;
    items_taken    = 0;
    no_idle        = 1'b0;
    // every input known from the start
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_ROW_WIDTH;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_plan = '{
      // flush straight after reset, no row yet: dropped
      item_row(OP_FLUSH, 8'h00, 1'b0, '0),
      SETTLE_ROW,
      // width below the minimum clamps to three; all weights zero gives zero everywhere
      cfg_row(REG_ROW_WIDTH, 16'd0),
      cfg_row(REG_CORNER, 16'd0),
      cfg_row(REG_EDGE, 16'd0),
      cfg_row(REG_CENTER, 16'd0),
      item_row(OP_PIXEL, 8'h00, 1'b0, '0),
      item_row(OP_PIXEL, 8'hFF, 1'b0, '0),
      item_row(OP_PIXEL, 8'h5A, 1'b0, '0),
      item_row(OP_PIXEL, 8'hA5, 1'b1, 16'd0),
      // flush in the middle of a row: dropped
      item_row(OP_FLUSH, 8'h00, 1'b0, '0),
      item_row(OP_PIXEL, 8'h00, 1'b1, 16'd0),
      item_row(OP_PIXEL, 8'hFF, 1'b1, 16'd0),
      item_row(OP_FLUSH, 8'h00, 1'b1, 16'd0),
      // pixel transaction during the flush acts as a flush step
      item_row(OP_PIXEL, 8'h3C, 1'b1, 16'd0),
      item_row(OP_FLUSH, 8'h00, 1'b1, 16'd0),
      SETTLE_ROW,
      // all weights at the top with white pixels saturates
      cfg_row(REG_ROW_WIDTH, 16'd3),
      cfg_row(REG_CORNER, 16'hFFFF),
      cfg_row(REG_EDGE, 16'hFFFF),
      cfg_row(REG_CENTER, 16'hFFFF),
      item_row(OP_PIXEL, 8'hFF, 1'b0, '0),
      item_row(OP_PIXEL, 8'hFF, 1'b0, '0),
      item_row(OP_PIXEL, 8'hFF, 1'b0, '0),
      item_row(OP_FLUSH, 8'h00, 1'b1, 16'hFFFF),
      item_row(OP_FLUSH, 8'hFF, 1'b1, 16'hFFFF),
      item_row(OP_FLUSH, 8'h00, 1'b1, 16'hFFFF),
      SETTLE_ROW,
      // default gaussian weights, then a row left unfinished before the width shrinks
      cfg_row(REG_ROW_WIDTH, 16'd4),
      cfg_row(REG_CORNER, CORNER_RST),
      cfg_row(REG_EDGE, EDGE_RST),
      cfg_row(REG_CENTER, CENTER_RST),
      item_row(OP_PIXEL, 8'd12, 1'b0, '0),
      item_row(OP_PIXEL, 8'd200, 1'b0, '0),
      item_row(OP_PIXEL, 8'd77, 1'b0, '0),
      item_row(OP_PIXEL, 8'd140, 1'b0, '0),
      item_row(OP_PIXEL, 8'd90, 1'b0, '0),
      item_row(OP_PIXEL, 8'd33, 1'b0, '0),
      item_row(OP_PIXEL, 8'd250, 1'b0, '0),
      SETTLE_ROW,
      // column past the new last column ends the row
      cfg_row(REG_ROW_WIDTH, 16'd3),
      item_row(OP_PIXEL, 8'd128, 1'b0, '0),
      item_row(OP_FLUSH, 8'h00, 1'b0, '0),
      item_row(OP_PIXEL, 8'd7, 1'b0, '0),
      item_row(OP_FLUSH, 8'h00, 1'b0, '0),
      SETTLE_ROW
    };

    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        STEP_ITEM:   send_item(directed_plan[i].op, directed_plan[i].pix,
                               directed_plan[i].fixed, directed_plan[i].fixed_px);
        STEP_CFG:    write_reg(directed_plan[i].reg_sel, directed_plan[i].cfg_val);
        STEP_SETTLE: settle_block();
        default: ;
      endcase
    end

    // random frames of small widths; the width only changes between frames,
    // so no row buffer column is read before it was written
    items_taken = 0;
    frame_idx   = 0;
    while (items_taken < RANDOM_ITEMS) begin
      // some frames run with no gaps and no stalls at all
      no_idle = (frame_idx % 5 == 3);
      pick = $urandom_range(0, 9);
      if (pick == 0) w_raw = $urandom_range(0, 2);
      else if (pick < 3) w_raw = $urandom_range(11, 40);
      else w_raw = $urandom_range(3, 10);
      // upper data bits do not belong to the width register
      run_frame({5'($urandom_range(0, 31)), 11'(w_raw)}, $urandom_range(1, 4));
      frame_idx++;
    end

    // top width code clamps to the widest row: a few columns there, then the
    // width drops to three so the next column ends the row, one more row and a flush
    no_idle = 1'b0;
    settle_block();
    write_reg(REG_ROW_WIDTH, 16'hFFFF);
    for (int c = 0; c < 8; c++) send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
    settle_block();
    write_reg(REG_ROW_WIDTH, 16'd3);
    send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
    for (int c = 0; c < 3; c++) send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
    for (int c = 0; c < 3; c++) send_item(OP_FLUSH, rand_pixel(), 1'b0, '0);

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
